// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge, masked while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/rc2_pkg.sv
package rc2_pkg;

   localparam int KEY_WORDS    = 64;
   localparam int KEY_AW       = $clog2(KEY_WORDS);
   localparam int WORD_W       = 16;
   localparam int BLOCK_W      = 64;
   localparam int NUM_WORDS    = BLOCK_W / WORD_W;
   localparam int ROUNDS       = 16;
   localparam int MASH_ROUND_A = 4;
   localparam int MASH_ROUND_B = 10;

   localparam logic [KEY_AW-1:0] MASH_STEP_A = KEY_AW'(NUM_WORDS * MASH_ROUND_A + 3);
   localparam logic [KEY_AW-1:0] MASH_STEP_B = KEY_AW'(NUM_WORDS * MASH_ROUND_B + 3);
   localparam logic [KEY_AW-1:0] LAST_STEP   = KEY_AW'(NUM_WORDS * ROUNDS - 1);
   localparam logic [KEY_AW-1:0] STEP_INC    = KEY_AW'(1);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 64;
   localparam logic [CSR_AW-1:0] IV_ADDR = CSR_AW'(0);

   localparam logic OP_KEY_WRITE = 1'b0;
   localparam logic OP_BIT       = 1'b1;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_type;

   // The first byte of the block is the low byte of word 0.
   function automatic words_type block_to_words(input logic [BLOCK_W-1:0] blk);
      words_type w;
      for (int j = 0; j < NUM_WORDS; j++) begin
         w[j] = {blk[BLOCK_W-9-16*j -: 8], blk[BLOCK_W-1-16*j -: 8]};
      end
      return w;
   endfunction

   function automatic logic [BLOCK_W-1:0] words_to_block(input words_type w);
      logic [BLOCK_W-1:0] blk;
      for (int j = 0; j < NUM_WORDS; j++) begin
         blk[BLOCK_W-1-16*j -: 8] = w[j][7:0];
         blk[BLOCK_W-9-16*j -: 8] = w[j][15:8];
      end
      return blk;
   endfunction

   function automatic word_type rotl_word(input word_type v, input logic [1:0] j);
      word_type r;
      unique case (j)
         2'd0: r = {v[14:0], v[15]};
         2'd1: r = {v[13:0], v[15:14]};
         2'd2: r = {v[12:0], v[15:13]};
         2'd3: r = {v[10:0], v[15:11]};
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

// File: design/rc2_bit_feedback_cipher.sv
// A key write transaction is taken one per cycle while the block is idle.
// A bit transaction runs 64 mixing steps and two mashes after acceptance, all paced by the
// single read port of the key table memory, and then shows its result.
// A new bit is taken only in idle; the result register lets the next bit start early.
// Synchronous reset clears the feedback register and iv to zero; the key table is not cleared.
module rc2_bit_feedback_cipher (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic [rc2_pkg::KEY_AW-1:0]  req_key_index,
   input  logic [rc2_pkg::WORD_W-1:0]  req_key_word,
   input  logic                        req_data_bit,
   input  logic                        req_decrypt,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_out_bit,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rc2_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [rc2_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [rc2_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   logic [rc2_pkg::BLOCK_W-1:0] iv;

   rc2_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .iv      (iv)
   );

   rc2_core u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_key_index (req_key_index),
      .req_key_word  (req_key_word),
      .req_data_bit  (req_data_bit),
      .req_decrypt   (req_decrypt),
      .req_restart   (req_restart),
      .iv            (iv),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_bit   (rsp_out_bit)
   );

endmodule

// File: design/rc2_ram.sv
module rc2_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/rc2_csr.sv
module rc2_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rc2_pkg::CSR_AW-1:0]  paddr,
   input  logic [rc2_pkg::CSR_DW-1:0]  pwdata,
   output logic [rc2_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output logic [rc2_pkg::BLOCK_W-1:0] iv
);

   logic [rc2_pkg::BLOCK_W-1:0] iv_ff;
   logic                        iv_we;

   assign pready = 1'b1;
   assign iv_we  = psel && penable && pwrite && (paddr == rc2_pkg::IV_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= '0;
      end else if (iv_we) begin
         iv_ff <= pwdata;
      end
   end

   assign prdata = (paddr == rc2_pkg::IV_ADDR) ? iv_ff : '0;
   assign iv     = iv_ff;

endmodule

// File: design/rc2_core.sv
module rc2_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [rc2_pkg::KEY_AW-1:0]   req_key_index,
   input  logic [rc2_pkg::WORD_W-1:0]   req_key_word,
   input  logic                         req_data_bit,
   input  logic                         req_decrypt,
   input  logic                         req_restart,
   input  logic [rc2_pkg::BLOCK_W-1:0]  iv,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_out_bit
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_MIX       = 3'd1;
   localparam logic [2:0] S_MASH_ADDR = 3'd2;
   localparam logic [2:0] S_MASH_ADD  = 3'd3;
   localparam logic [2:0] S_FINISH    = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [rc2_pkg::KEY_AW-1:0]  step_ff, step_in;
   logic [1:0]                  mash_ff, mash_in;
   rc2_pkg::words_type          words_ff, words_in;
   logic [rc2_pkg::BLOCK_W-1:0] fb_ff, fb_in;
   logic                        din_ff, din_in;
   logic                        decrypt_ff, decrypt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_bit_ff, rsp_bit_in;

   logic                        accept;
   logic                        key_we;
   logic [rc2_pkg::KEY_AW-1:0]  rd_addr;
   rc2_pkg::word_type           key_rd;

   logic [1:0]                  j0, j1, j2, j3, m_prev;
   rc2_pkg::word_type           mix_sum, mix_word, mash_word;
   logic [rc2_pkg::BLOCK_W-1:0] enc;
   logic                        obit, fbbit;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign key_we    = accept && (req_op == rc2_pkg::OP_KEY_WRITE);

   rc2_ram #(
      .WIDTH (rc2_pkg::WORD_W),
      .DEPTH (rc2_pkg::KEY_WORDS)
   ) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (req_key_index),
      .wdata (req_key_word),
      .raddr (rd_addr),
      .rdata (key_rd)
   );

   assign j0       = step_ff[1:0];
   assign j1       = j0 + 2'd1;
   assign j2       = j0 + 2'd2;
   assign j3       = j0 + 2'd3;
   assign mix_sum  = words_ff[j0] + (words_ff[j1] & ~words_ff[j3])
                   + (words_ff[j2] & words_ff[j3]) + key_rd;
   assign mix_word = rc2_pkg::rotl_word(mix_sum, j0);

   assign m_prev    = mash_ff - 2'd1;
   assign mash_word = words_ff[mash_ff] + key_rd;

   assign enc   = rc2_pkg::words_to_block(words_ff);
   assign obit  = din_ff ^ enc[0];
   assign fbbit = decrypt_ff ? din_ff : obit;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mash_in      = mash_ff;
      words_in     = words_ff;
      fb_in        = fb_ff;
      din_in       = din_ff;
      decrypt_in   = decrypt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_bit_in   = rsp_bit_ff;
      rd_addr      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == rc2_pkg::OP_BIT)) begin
               words_in   = rc2_pkg::block_to_words(req_restart ? iv : fb_ff);
               din_in     = req_data_bit;
               decrypt_in = req_decrypt;
               step_in    = '0;
               state_in   = S_MIX;
            end
         end
         S_MIX: begin
            rd_addr      = step_ff + rc2_pkg::STEP_INC;
            words_in[j0] = mix_word;
            step_in      = step_ff + rc2_pkg::STEP_INC;
            if ((step_ff == rc2_pkg::MASH_STEP_A) || (step_ff == rc2_pkg::MASH_STEP_B)) begin
               step_in  = step_ff;
               mash_in  = '0;
               state_in = S_MASH_ADDR;
            end else if (step_ff == rc2_pkg::LAST_STEP) begin
               state_in = S_FINISH;
            end
         end
         S_MASH_ADDR: begin
            rd_addr  = words_ff[m_prev][rc2_pkg::KEY_AW-1:0];
            state_in = S_MASH_ADD;
         end
         S_MASH_ADD: begin
            rd_addr           = step_ff + rc2_pkg::STEP_INC;
            words_in[mash_ff] = mash_word;
            mash_in           = mash_ff + 2'd1;
            if (mash_ff == 2'd3) begin
               step_in  = step_ff + rc2_pkg::STEP_INC;
               state_in = S_MIX;
            end else begin
               state_in = S_MASH_ADDR;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = obit;
               fb_in        = {enc[rc2_pkg::BLOCK_W-2:0], fbbit};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         mash_ff      <= '0;
         fb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         mash_ff      <= mash_in;
         fb_ff        <= fb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      words_ff   <= words_in;
      din_ff     <= din_in;
      decrypt_ff <= decrypt_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_bit = rsp_bit_ff;

endmodule

// File: design/rc2_checker.sv
`include "assert_macros.svh"

module rc2_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_op,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_out_bit
);

   `ASSERT_ALWAYS(a_rsp_clear_after_reset, clock, reset |=> !rsp_valid, "Response valid after reset")
   `ASSERT_CLK(a_bit_blocks_input, clock, reset, (req_valid && req_ready && req_op) |=> !req_ready, "Input taken while a bit transaction is in progress")
   `ASSERT_CLK(a_key_write_no_rsp, clock, reset, (req_valid && req_ready && !req_op && !rsp_valid) |=> !rsp_valid, "Key write transaction produced a response")
   `ASSERT_CLK(a_rsp_holds, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "Response dropped before acceptance")
   `ASSERT_CLK(a_rsp_stable, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(rsp_out_bit), "Response bit changed while stalled")

endmodule

bind rc2_bit_feedback_cipher rc2_checker u_rc2_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_op      (req_op),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_out_bit (rsp_out_bit)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int KEY_AW        = rc2_pkg::KEY_AW;
   localparam int WORD_W        = rc2_pkg::WORD_W;
   localparam int KEY_WORDS     = rc2_pkg::KEY_WORDS;
   localparam int CIPHER_ROUNDS = 16;
   localparam int DRAIN_CYCLES  = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 600000;

   typedef struct packed {
      logic              op;
      logic [KEY_AW-1:0] key_index;
      logic [WORD_W-1:0] key_word;
      logic              data_bit;
      logic              decrypt;
      logic              restart;
      logic              typed;
      logic              typed_out;
   } stim_row_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_op;
   logic [KEY_AW-1:0]          req_key_index;
   logic [WORD_W-1:0]          req_key_word;
   logic                       req_data_bit;
   logic                       req_decrypt;
   logic                       req_restart;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_out_bit;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [rc2_pkg::CSR_AW-1:0] csr_paddr;
   logic [rc2_pkg::CSR_DW-1:0] csr_pwdata;
   logic [rc2_pkg::CSR_DW-1:0] csr_prdata;
   logic                       csr_pready;

   logic [WORD_W-1:0] key_mem [KEY_WORDS];
   logic [63:0]       feedback;
   logic [63:0]       iv_model;
   logic              expected_bits [$];
   int                fail_count = 0;
   int                cycle_count = 0;
   bit                quiet = 1'b0;
   bit                hold_off_request = 1'b0;

   // With an all-zero key table and a zero iv, a restarted bit sees a zero keystream bit.
   stim_row_type directed_rows [0:19] = '{
      '{rc2_pkg::OP_BIT,       6'd0,  16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0},
      '{rc2_pkg::OP_BIT,       6'd0,  16'h0000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1},
      '{rc2_pkg::OP_BIT,       6'd0,  16'h0000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
      '{rc2_pkg::OP_BIT,       6'd63, 16'hffff, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{rc2_pkg::OP_BIT,       6'd63, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{rc2_pkg::OP_BIT,       6'd0,  16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{rc2_pkg::OP_KEY_WRITE, 6'd0,  16'hffff, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
      '{rc2_pkg::OP_KEY_WRITE, 6'd63, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{rc2_pkg::OP_KEY_WRITE, 6'd21, 16'h5555, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
      '{rc2_pkg::OP_KEY_WRITE, 6'd42, 16'haaaa, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{rc2_pkg::OP_BIT,       6'd21, 16'h5555, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
      '{rc2_pkg::OP_BIT,       6'd42, 16'haaaa, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{rc2_pkg::OP_BIT,       6'd0,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{rc2_pkg::OP_BIT,       6'd63, 16'hffff, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{rc2_pkg::OP_BIT,       6'd0,  16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
      '{rc2_pkg::OP_KEY_WRITE, 6'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{rc2_pkg::OP_KEY_WRITE, 6'd63, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
      '{rc2_pkg::OP_BIT,       6'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{rc2_pkg::OP_BIT,       6'd63, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{rc2_pkg::OP_BIT,       6'd0,  16'h0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}
   };

   rc2_bit_feedback_cipher u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_key_index (req_key_index),
      .req_key_word  (req_key_word),
      .req_data_bit  (req_data_bit),
      .req_decrypt   (req_decrypt),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_bit   (rsp_out_bit),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic logic [15:0] rotl16(input logic [15:0] v, input int n);
      return (v << n) | (v >> (16 - n));
   endfunction

   function automatic logic [63:0] rc2_encrypt_block(input logic [63:0] blk);
      logic [15:0]       w [4];
      logic [15:0]       sum;
      logic [KEY_AW-1:0] k;
      logic [63:0]       res;
      for (int j = 0; j < 4; j++) begin
         w[j] = {blk[55-16*j -: 8], blk[63-16*j -: 8]};
      end
      for (int r = 0; r < CIPHER_ROUNDS; r++) begin
         for (int j = 0; j < 4; j++) begin
            k = KEY_AW'(4 * r + j);
            sum = w[j] + (w[(j+1)%4] & ~w[(j+3)%4]) + (w[(j+2)%4] & w[(j+3)%4]) + key_mem[k];
            w[j] = rotl16(sum, (j == 3) ? 5 : j + 1);
         end
         if (r == rc2_pkg::MASH_ROUND_A || r == rc2_pkg::MASH_ROUND_B) begin
            for (int j = 0; j < 4; j++) begin
               w[j] = w[j] + key_mem[w[(j+3)%4][KEY_AW-1:0]];
            end
         end
      end
      for (int j = 0; j < 4; j++) begin
         res[63-16*j -: 8] = w[j][7:0];
         res[55-16*j -: 8] = w[j][15:8];
      end
      return res;
   endfunction

   task automatic cfb1_step(input stim_row_type t, output logic produced, output logic out_bit);
      logic [63:0] enc;
      logic        fb;
      produced = 1'b0;
      out_bit  = 1'b0;
      if (t.op == rc2_pkg::OP_KEY_WRITE) begin
         key_mem[t.key_index] = t.key_word;
      end else begin
         if (t.restart) begin
            feedback = iv_model;
         end
         enc      = rc2_encrypt_block(feedback);
         out_bit  = t.data_bit ^ enc[0];
         fb       = t.decrypt ? t.data_bit : out_bit;
         feedback = {enc[62:0], fb};
         produced = 1'b1;
      end
   endtask

   function automatic stim_row_type random_row(input logic op, input logic dec, input logic rst);
      stim_row_type row;
      row.op        = op;
      row.key_index = KEY_AW'($urandom);
      row.key_word  = WORD_W'($urandom);
      row.data_bit  = 1'($urandom);
      row.decrypt   = dec;
      row.restart   = rst;
      row.typed     = 1'b0;
      row.typed_out = 1'b0;
      return row;
   endfunction

   task automatic send_req(input stim_row_type row);
      logic produced;
      logic predicted;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_op        = row.op;
      req_key_index = row.key_index;
      req_key_word  = row.key_word;
      req_data_bit  = row.data_bit;
      req_decrypt   = row.decrypt;
      req_restart   = row.restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cfb1_step(row, produced, predicted);
      if (produced) begin
         expected_bits.push_back(row.typed ? row.typed_out : predicted);
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic load_key_table(input bit all_zero);
      stim_row_type row;
      for (int i = 0; i < KEY_WORDS; i++) begin
         row = random_row(rc2_pkg::OP_KEY_WRITE, 1'($urandom), 1'($urandom));
         row.key_index = KEY_AW'(i);
         if (all_zero) begin
            row.key_word = '0;
         end
         send_req(row);
      end
   endtask

   // Mostly frames that open with a restart and keep one direction, with some broken ones.
   task automatic send_frames(input int n_items);
      int           sent;
      int           len;
      logic         dec;
      logic         rst;
      stim_row_type row;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 7) == 0) begin
            send_req(random_row(rc2_pkg::OP_KEY_WRITE, 1'($urandom), 1'($urandom)));
            sent++;
         end else begin
            len = $urandom_range(1, 40);
            dec = 1'($urandom);
            for (int i = 0; i < len; i++) begin
               rst = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
               row = random_row(rc2_pkg::OP_BIT, ($urandom_range(0, 29) == 0) ? ~dec : dec, rst);
               send_req(row);
               sent++;
            end
         end
      end
   endtask

   task automatic csr_access(input logic wr, input logic [63:0] wdata,
                             output logic [63:0] rdata);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = rc2_pkg::IV_ADDR;
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      if (wr) begin
         iv_model = wdata;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic check_iv();
      logic [63:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd !== iv_model) begin
         $display("%0t: iv readback mismatch, expected %h, actual %h", $time, iv_model, rd);
         fail_count++;
      end
   endtask

   task automatic program_iv(input logic [63:0] value);
      logic [63:0] rd;
      csr_access(1'b1, value, rd);
      check_iv();
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (expected_bits.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      logic exp_bit;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bits.size() == 0) begin
            $display("%0t: out_bit %0b arrived with no transaction pending", $time,
                     rsp_out_bit);
            fail_count++;
         end else begin
            exp_bit = expected_bits.pop_front();
            if (rsp_out_bit !== exp_bit) begin
               $display("%0t: out_bit mismatch, expected %0b, actual %0b", $time, exp_bit,
                        rsp_out_bit);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** rc2_bit_feedback_cipher: FAILED **");
         $finish;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready = 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = rc2_pkg::OP_KEY_WRITE;
      req_key_index = '0;
      req_key_word  = '0;
      req_data_bit  = 1'b0;
      req_decrypt   = 1'b0;
      req_restart   = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = rc2_pkg::IV_ADDR;
      csr_pwdata    = '0;
      feedback      = '0;
      iv_model      = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      check_iv();
      load_key_table(1'b1);
      foreach (directed_rows[i]) begin
         send_req(directed_rows[i]);
      end

      wait_idle();
      program_iv(64'hffff_ffff_ffff_ffff);
      load_key_table(1'b0);
      hold_off_request = 1'b1;
      send_frames(240);

      wait_idle();
      program_iv({$urandom, $urandom});
      send_frames(240);

      wait_idle();
      quiet = 1'b1;
      program_iv('0);
      send_frames(240);

      wait_idle();
      if (fail_count == 0) begin
         $display("** rc2_bit_feedback_cipher: PASSED **");
      end else begin
         $display("** rc2_bit_feedback_cipher: FAILED **");
      end
      $finish;
   end

endmodule
